### rtl/ffec_pkg.sv
// Shared types, codes and constants of the four-floor elevator controller.
package ffec_pkg;

  localparam int FLOORS_DEFAULT = 4;

  // Longest run of phases one tick can pass through (idle up to dwell).
  localparam int CHAIN_STEPS = 9;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_DOOR_CLOSE = 4'd1;
  localparam logic [3:0] PH_CLOSING    = 4'd2;
  localparam logic [3:0] PH_CHOOSE     = 4'd3;
  localparam logic [3:0] PH_TRAVEL     = 4'd4;
  localparam logic [3:0] PH_ARRIVE     = 4'd5;
  localparam logic [3:0] PH_OPENING    = 4'd6;
  localparam logic [3:0] PH_OPENED     = 4'd7;
  localparam logic [3:0] PH_DWELL      = 4'd8;

  localparam logic [3:0] MSG_BLANK     = 4'd0;
  localparam logic [3:0] MSG_CLOSING   = 4'd1;
  localparam logic [3:0] MSG_CLOSED    = 4'd2;
  localparam logic [3:0] MSG_UP        = 4'd3;
  localparam logic [3:0] MSG_DOWN      = 4'd4;
  localparam logic [3:0] MSG_ONE_FLOOR = 4'd5;
  localparam logic [3:0] MSG_OPENING   = 4'd6;
  localparam logic [3:0] MSG_OPENED    = 4'd7;
  localparam logic [3:0] MSG_WAITING   = 4'd8;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [0:0] REQ_TICK   = 1'b0;
  localparam logic [0:0] REQ_BUTTON = 1'b1;

  localparam logic [2:0] CFG_START_WAIT = 3'd0;
  localparam logic [2:0] CFG_DOOR_MOVE  = 3'd1;
  localparam logic [2:0] CFG_TRAVEL     = 3'd2;
  localparam logic [2:0] CFG_DWELL      = 3'd3;
  localparam logic [2:0] CFG_FLOW_STEP  = 3'd4;
  localparam logic [2:0] CFG_MOTOR_UP   = 3'd5;
  localparam logic [2:0] CFG_MOTOR_DOWN = 3'd6;

  localparam logic [15:0] START_WAIT_RESET = 16'd1000;
  localparam logic [15:0] DOOR_MOVE_RESET  = 16'd4000;
  localparam logic [15:0] TRAVEL_RESET     = 16'd6000;
  localparam logic [15:0] DWELL_RESET      = 16'd2000;
  localparam logic [15:0] FLOW_STEP_RESET  = 16'd300;
  localparam logic [9:0]  MOTOR_UP_RESET   = 10'd800;
  localparam logic [9:0]  MOTOR_DOWN_RESET = 10'd600;

  localparam logic [8:0]  DOOR_CLOSE_CMP = 9'd250;
  localparam logic [8:0]  DOOR_OPEN_CMP  = 9'd300;
  localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

  localparam logic [7:0] FLOW_RESET = 8'h10;
  localparam logic [7:0] FLOW_LOW   = 8'h08;
  localparam logic [7:0] FLOW_TOP   = 8'h80;

  typedef struct packed {
    logic [15:0] start_wait;
    logic [15:0] door_move;
    logic [15:0] travel;
    logic [15:0] dwell;
    logic [15:0] flow_step;
    logic [9:0]  motor_up_cmp;
    logic [9:0]  motor_down_cmp;
  } cfg_t;

  typedef struct packed {
    logic [0:0] req_type;
    logic [2:0] button;
  } item_t;

  typedef struct packed {
    logic [2:0] floor;
    logic [3:0] requests;
    logic [7:0] led_pattern;
    logic       motor_on;
    logic       motor_up;
    logic [9:0] motor_compare;
    logic       door_on;
    logic       door_opening;
    logic [8:0] door_compare;
    logic [3:0] message;
    logic [3:0] phase;
  } result_t;

endpackage

### rtl/ffec_cfg_regs.sv
// Configuration register file of the elevator controller.
module ffec_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output ffec_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_wait     <= ffec_pkg::START_WAIT_RESET;
      cfg.door_move      <= ffec_pkg::DOOR_MOVE_RESET;
      cfg.travel         <= ffec_pkg::TRAVEL_RESET;
      cfg.dwell          <= ffec_pkg::DWELL_RESET;
      cfg.flow_step      <= ffec_pkg::FLOW_STEP_RESET;
      cfg.motor_up_cmp   <= ffec_pkg::MOTOR_UP_RESET;
      cfg.motor_down_cmp <= ffec_pkg::MOTOR_DOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ffec_pkg::CFG_START_WAIT: cfg.start_wait     <= cfg_data;
        ffec_pkg::CFG_DOOR_MOVE:  cfg.door_move      <= cfg_data;
        ffec_pkg::CFG_TRAVEL:     cfg.travel         <= cfg_data;
        ffec_pkg::CFG_DWELL:      cfg.dwell          <= cfg_data;
        ffec_pkg::CFG_FLOW_STEP:  cfg.flow_step      <= cfg_data;
        ffec_pkg::CFG_MOTOR_UP:   cfg.motor_up_cmp   <= cfg_data[9:0];
        ffec_pkg::CFG_MOTOR_DOWN: cfg.motor_down_cmp <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/ffec_ctrl.sv
// Controller state and single-pass phase sequencer of the elevator controller.
module ffec_ctrl #(
  parameter int FLOORS = ffec_pkg::FLOORS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              apply,
  input  ffec_pkg::item_t   item,
  input  ffec_pkg::cfg_t    cfg,
  output ffec_pkg::result_t result
);

  localparam int FLW = $clog2(FLOORS + 1);
  localparam logic [FLOORS-1:0] ONE_HOT_LOW = FLOORS'(1);

  logic [3:0]        phase, phase_next;
  logic [FLW-1:0]    flr, flr_next;
  logic [FLOORS-1:0] req, req_next;
  logic [1:0]        dir, dir_next;
  logic [7:0]        flow, flow_next;
  logic [7:0]        led, led_next;
  logic [15:0]       ptimer, ptimer_next;
  logic [15:0]       ftimer, ftimer_next;
  logic              motor_on, motor_on_next;
  logic              motor_up, motor_up_next;
  logic [9:0]        motor_cmp, motor_cmp_next;
  logic              door_on, door_on_next;
  logic              door_opening, door_opening_next;
  logic [8:0]        door_cmp, door_cmp_next;
  logic [3:0]        msg, msg_next;

  logic [15:0] t_inc;
  logic        start_t, start_z, door_t, door_z, travel_t, travel_z, dwell_t, dwell_z;
  logic [16:0] ft_inc;
  logic        ft_wrap, ft_zero_wrap;
  logic        btn_ok;
  logic        go, tz, ftz;
  logic [15:0] shifted;
  logic [FLOORS+3:0] req_pad;
  logic [FLW+2:0]    flr_pad;

  function automatic logic [FLOORS-1:0] floor_bit(input logic [FLW-1:0] f);
    logic [FLW-1:0] fc;
    fc = f;
    if (fc == '0) fc = FLW'(1);
    if (32'(fc) > FLOORS) fc = FLW'(FLOORS);
    return ONE_HOT_LOW << (fc - FLW'(1));
  endfunction

  function automatic logic [3:0] req_nibble(input logic [FLOORS-1:0] r);
    logic [FLOORS+3:0] p;
    p = {4'b0000, r};
    return p[3:0];
  endfunction

  // Returns {flow, led} after one running-light step.
  function automatic logic [15:0] shift_light(input logic [1:0] d, input logic [7:0] fb,
                                              input logic [7:0] ld);
    logic [7:0] f;
    logic [7:0] l;
    f = fb;
    l = ld;
    if (d == ffec_pkg::DIR_UP) begin
      f = f >> 1;
      if (f == ffec_pkg::FLOW_LOW) f = ffec_pkg::FLOW_TOP;
      l = {f[7:4], l[3:0]};
    end else if (d == ffec_pkg::DIR_DOWN) begin
      l = {f[7:4], l[3:0]};
      f = f << 1;
      if (f == 8'h00) f = ffec_pkg::FLOW_RESET;
    end
    return {f, l};
  endfunction

  // Compares against the incremented timer or against a timer just cleared.
  assign t_inc    = (ptimer != ffec_pkg::TIMER_MAX) ? ptimer + 16'd1 : ptimer;
  assign start_t  = t_inc >= cfg.start_wait;
  assign start_z  = cfg.start_wait == 16'd0;
  assign door_t   = t_inc >= cfg.door_move;
  assign door_z   = cfg.door_move == 16'd0;
  assign travel_t = t_inc >= cfg.travel;
  assign travel_z = cfg.travel == 16'd0;
  assign dwell_t  = t_inc >= cfg.dwell;
  assign dwell_z  = cfg.dwell == 16'd0;

  assign ft_inc       = {1'b0, ftimer} + 17'd1;
  assign ft_wrap      = ft_inc >= {1'b0, cfg.flow_step};
  assign ft_zero_wrap = cfg.flow_step <= 16'd1;

  assign btn_ok = (item.button != 3'd0) && (32'(item.button) <= FLOORS);

  always_comb begin
    phase_next        = phase;
    flr_next          = flr;
    req_next          = req;
    dir_next          = dir;
    flow_next         = flow;
    led_next          = led;
    ptimer_next       = ptimer;
    ftimer_next       = ftimer;
    motor_on_next     = motor_on;
    motor_up_next     = motor_up;
    motor_cmp_next    = motor_cmp;
    door_on_next      = door_on;
    door_opening_next = door_opening;
    door_cmp_next     = door_cmp;
    msg_next          = msg;
    go                = 1'b0;
    tz                = 1'b0;
    ftz               = 1'b0;
    shifted           = {flow, led};
    if (apply) begin
      if (item.req_type == ffec_pkg::REQ_TICK) begin
        ptimer_next = t_inc;
        go = (req != '0);
        for (int i = 0; i < ffec_pkg::CHAIN_STEPS; i++) begin
          if (go) begin
            case (phase_next)
              ffec_pkg::PH_IDLE: begin
                if (tz ? start_z : start_t) phase_next = ffec_pkg::PH_DOOR_CLOSE;
                else go = 1'b0;
              end
              ffec_pkg::PH_DOOR_CLOSE: begin
                door_opening_next = 1'b0;
                door_cmp_next     = ffec_pkg::DOOR_CLOSE_CMP;
                door_on_next      = 1'b1;
                msg_next          = ffec_pkg::MSG_CLOSING;
                ptimer_next       = 16'd0;
                tz                = 1'b1;
                phase_next        = ffec_pkg::PH_CLOSING;
              end
              ffec_pkg::PH_CLOSING: begin
                if (tz ? door_z : door_t) begin
                  door_on_next = 1'b0;
                  msg_next     = ffec_pkg::MSG_CLOSED;
                  phase_next   = ffec_pkg::PH_CHOOSE;
                end else go = 1'b0;
              end
              ffec_pkg::PH_CHOOSE: begin
                if (req_next > floor_bit(flr_next)) begin
                  dir_next       = ffec_pkg::DIR_UP;
                  motor_up_next  = 1'b1;
                  motor_cmp_next = cfg.motor_up_cmp;
                  motor_on_next  = 1'b1;
                  msg_next       = ffec_pkg::MSG_UP;
                end else if (req_next < floor_bit(flr_next)) begin
                  dir_next       = ffec_pkg::DIR_DOWN;
                  motor_up_next  = 1'b0;
                  motor_cmp_next = cfg.motor_down_cmp;
                  motor_on_next  = 1'b1;
                  msg_next       = ffec_pkg::MSG_DOWN;
                end
                ptimer_next = 16'd0;
                tz          = 1'b1;
                ftimer_next = 16'd0;
                ftz         = 1'b1;
                phase_next  = ffec_pkg::PH_TRAVEL;
              end
              ffec_pkg::PH_TRAVEL: begin
                if (tz ? travel_z : travel_t) begin
                  if (dir_next == ffec_pkg::DIR_UP && 32'(flr_next) < FLOORS)
                    flr_next = FLW'(flr_next + FLW'(1));
                  else if (dir_next == ffec_pkg::DIR_DOWN && flr_next > FLW'(1))
                    flr_next = FLW'(flr_next - FLW'(1));
                  msg_next      = ffec_pkg::MSG_ONE_FLOOR;
                  led_next[7:4] = 4'h0;
                  flow_next     = ffec_pkg::FLOW_RESET;
                  phase_next    = ffec_pkg::PH_ARRIVE;
                end else begin
                  if (ftz || ftimer == 16'd0) begin
                    shifted   = shift_light(dir_next, flow_next, led_next);
                    flow_next = shifted[15:8];
                    led_next  = shifted[7:0];
                  end
                  if (ftz) ftimer_next = ft_zero_wrap ? 16'd0 : 16'd1;
                  else     ftimer_next = ft_wrap ? 16'd0 : ft_inc[15:0];
                  go = 1'b0;
                end
              end
              ffec_pkg::PH_ARRIVE: begin
                if ((req_next & floor_bit(flr_next)) != '0) begin
                  motor_on_next     = 1'b0;
                  door_opening_next = 1'b1;
                  door_cmp_next     = ffec_pkg::DOOR_OPEN_CMP;
                  door_on_next      = 1'b1;
                  msg_next          = ffec_pkg::MSG_OPENING;
                  ptimer_next       = 16'd0;
                  tz                = 1'b1;
                  phase_next        = ffec_pkg::PH_OPENING;
                end else begin
                  ptimer_next = 16'd0;
                  tz          = 1'b1;
                  ftimer_next = 16'd0;
                  ftz         = 1'b1;
                  phase_next  = ffec_pkg::PH_TRAVEL;
                  go          = 1'b0;
                end
              end
              ffec_pkg::PH_OPENING: begin
                if (tz ? door_z : door_t) begin
                  door_on_next  = 1'b0;
                  msg_next      = ffec_pkg::MSG_OPENED;
                  req_next      = req_next & ~floor_bit(flr_next);
                  led_next[3:0] = req_nibble(req_next);
                  phase_next    = ffec_pkg::PH_OPENED;
                end else go = 1'b0;
              end
              ffec_pkg::PH_OPENED: begin
                if (req_next != '0) begin
                  ptimer_next = 16'd0;
                  tz          = 1'b1;
                  msg_next    = ffec_pkg::MSG_WAITING;
                  phase_next  = ffec_pkg::PH_DWELL;
                end else begin
                  phase_next = ffec_pkg::PH_IDLE;
                  msg_next   = ffec_pkg::MSG_BLANK;
                  go         = 1'b0;
                end
              end
              ffec_pkg::PH_DWELL: begin
                if (tz ? dwell_z : dwell_t) begin
                  msg_next   = ffec_pkg::MSG_BLANK;
                  phase_next = ffec_pkg::PH_DOOR_CLOSE;
                end
                go = 1'b0;
              end
              default: go = 1'b0;
            endcase
          end
        end
      end else if (phase == ffec_pkg::PH_IDLE && btn_ok) begin
        if (32'(flr) != 32'(item.button))
          req_next = req | (ONE_HOT_LOW << (item.button - 3'd1));
        led_next[3:0] = req_nibble(req_next);
        ptimer_next   = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ffec_pkg::PH_IDLE;
      flr          <= FLW'(1);
      req          <= '0;
      dir          <= ffec_pkg::DIR_NONE;
      flow         <= ffec_pkg::FLOW_RESET;
      led          <= 8'h00;
      ptimer       <= 16'd0;
      ftimer       <= 16'd0;
      motor_on     <= 1'b0;
      motor_up     <= 1'b0;
      motor_cmp    <= 10'd0;
      door_on      <= 1'b0;
      door_opening <= 1'b0;
      door_cmp     <= 9'd0;
      msg          <= ffec_pkg::MSG_BLANK;
    end else begin
      phase        <= phase_next;
      flr          <= flr_next;
      req          <= req_next;
      dir          <= dir_next;
      flow         <= flow_next;
      led          <= led_next;
      ptimer       <= ptimer_next;
      ftimer       <= ftimer_next;
      motor_on     <= motor_on_next;
      motor_up     <= motor_up_next;
      motor_cmp    <= motor_cmp_next;
      door_on      <= door_on_next;
      door_opening <= door_opening_next;
      door_cmp     <= door_cmp_next;
      msg          <= msg_next;
    end
  end

  assign req_pad = {4'b0000, req};
  assign flr_pad = {3'b000, flr};

  assign result.floor         = flr_pad[2:0];
  assign result.requests      = req_pad[3:0];
  assign result.led_pattern   = led;
  assign result.motor_on      = motor_on;
  assign result.motor_up      = motor_up;
  assign result.motor_compare = motor_cmp;
  assign result.door_on       = door_on;
  assign result.door_opening  = door_opening;
  assign result.door_compare  = door_cmp;
  assign result.message       = msg;
  assign result.phase         = phase;

endmodule

### rtl/four_floor_elevator_controller_core.sv
// Top level of the elevator controller: input register, controller state and result handshake.
// Latency: an accepted transaction waits in the input register until the result slot is free,
//   is then applied to the controller state, and its result is offered on the out channel.
// Throughput: one transaction per cycle while results are taken; the whole phase sequence for
//   a tick is resolved in the single combinational pass between input and state registers.
// Reset: synchronous, active high; clears the handshake, the controller state and loads
//   the default timing and motor compare registers. No clearing pass is needed.
module four_floor_elevator_controller_core #(
  parameter int FLOORS = ffec_pkg::FLOORS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  req_type,
  input  logic [2:0]  button,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  floor,
  output logic [3:0]  requests,
  output logic [7:0]  led_pattern,
  output logic        motor_on,
  output logic        motor_up,
  output logic [9:0]  motor_compare,
  output logic        door_on,
  output logic        door_opening,
  output logic [8:0]  door_compare,
  output logic [3:0]  message,
  output logic [3:0]  phase,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ffec_pkg::cfg_t    cfg;
  ffec_pkg::item_t   hold_item;
  ffec_pkg::result_t result;
  logic              hold_valid;
  logic              advance;
  logic              apply;

  // The result slot frees up when it is empty or being taken this cycle.
  assign advance  = !out_valid || out_ready;
  // The input register takes a new transaction when it is empty or its own item
  // moves on; a waiting result blocks the input side only once this register is full.
  assign in_ready = !hold_valid || advance;
  assign apply    = hold_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (apply) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.req_type <= req_type;
      hold_item.button   <= button;
    end
  end

  // The controller state doubles as the result register: it changes only when
  // an item is applied, which happens only when the previous result is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  ffec_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ffec_ctrl #(
    .FLOORS (FLOORS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .apply  (apply),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  assign floor         = result.floor;
  assign requests      = result.requests;
  assign led_pattern   = result.led_pattern;
  assign motor_on      = result.motor_on;
  assign motor_up      = result.motor_up;
  assign motor_compare = result.motor_compare;
  assign door_on       = result.door_on;
  assign door_opening  = result.door_opening;
  assign door_compare  = result.door_compare;
  assign message       = result.message;
  assign phase         = result.phase;

endmodule

### rtl/ffec_checker.sv
// Port-level assertions for the elevator controller, bound to the top level.
module ffec_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  floor,
  input logic [3:0]  requests,
  input logic        motor_on,
  input logic        door_on,
  input logic [3:0]  message,
  input logic [3:0]  phase
);

  // Drop any pending result on reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still offered after reset");

  // Input side stalls only behind a result that is waiting.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(floor) && $stable(requests)
                                   && $stable(phase) && $stable(message)))
    else $error("stalled result changed");

  // Motor and door never run together.
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(motor_on && door_on))
    else $error("motor and door running together");

  // Idle controller has motor and door stopped.
  a_idle_stopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == ffec_pkg::PH_IDLE) |-> (!motor_on && !door_on))
    else $error("actuator running while idle");

endmodule

bind four_floor_elevator_controller_core ffec_checker u_ffec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .floor     (floor),
  .requests  (requests),
  .motor_on  (motor_on),
  .door_on   (door_on),
  .message   (message),
  .phase     (phase)
);
